/* hw/rtl/jsu_pkg.sv */
// jsu_pkg: shared types and constants of the json string unescaper
// used by the front decoder, the job queue, the back serialiser and the top level
package jsu_pkg;

  localparam int COUNT_BITS = 16;
  localparam int OUT_CNT_W  = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // one decoded input byte: up to four data beats and an optional status beat
  typedef struct packed {
    logic [3:0][7:0]       bytes;
    logic [2:0]            n;
    logic [1:0]            status;
    logic [OUT_CNT_W-1:0]  chars;
    logic [OUT_CNT_W-1:0]  dbytes;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/jsu_front.sv */
// jsu_front: accepts raw bytes, runs the escape and \u decoder, builds jobs
// depends on jsu_pkg
module jsu_front import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  q_status_t   q_stat,
  output logic        push,
  output job_t        push_job
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_STR     = 3'd1;
  localparam logic [2:0] MODE_ESC     = 3'd2;
  localparam logic [2:0] MODE_HEX_HI  = 3'd3;
  localparam logic [2:0] MODE_WAIT_BS = 3'd4;
  localparam logic [2:0] MODE_WAIT_U  = 3'd5;
  localparam logic [2:0] MODE_HEX_LO  = 3'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam int CW1 = COUNT_BITS + 1;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } enc_t;

  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic enc_t utf8_enc(logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.n = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.n = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.n = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.n = 3'd4;
    end
    return e;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a, logic [2:0] inc);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + CW1'(inc);
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  logic [2:0]            mode_r, mode_nxt;
  logic [15:0]           hex_r, hex_nxt;
  logic [2:0]            digits_r, digits_nxt;
  logic [9:0]            high_r, high_nxt;
  logic [COUNT_BITS-1:0] chars_r, chars_nxt, chars_mid;
  logic [COUNT_BITS-1:0] bytes_r, bytes_nxt, bytes_mid;

  logic            accept;
  logic [4:0]      hd;
  logic [15:0]     hv;
  logic [1:0]      status;
  enc_t            enc;
  logic [20:0]     cp;

  assign accept = in_valid && !q_stat.full;
  assign hd     = hex_digit(in_byte);
  assign hv     = {hex_r[11:0], hd[3:0]};

  always_comb begin
    mode_nxt   = mode_r;
    hex_nxt    = hex_r;
    digits_nxt = digits_r;
    high_nxt   = high_r;
    chars_mid  = chars_r;
    bytes_mid  = bytes_r;
    status     = ST_RUN;
    enc.bytes  = '0;
    enc.n      = 3'd0;
    cp         = 21'd0;
    unique case (mode_r)
      MODE_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          chars_mid  = '0;
          bytes_mid  = '0;
          hex_nxt    = '0;
          digits_nxt = '0;
          high_nxt   = '0;
          mode_nxt   = MODE_STR;
        end else begin
          status = ST_ERR;
        end
      end
      MODE_STR: begin
        if (in_byte == CH_QUOTE) begin
          status = ST_DONE;
        end else if (in_byte == CH_BSL) begin
          mode_nxt = MODE_ESC;
        end else begin
          enc.bytes[0] = in_byte;
          enc.n = 3'd1;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_STR;
        enc.n = 3'd1;
        unique case (in_byte)
          CH_B:    enc.bytes[0] = 8'h08;
          CH_F:    enc.bytes[0] = 8'h0C;
          CH_N:    enc.bytes[0] = 8'h0A;
          CH_R:    enc.bytes[0] = 8'h0D;
          CH_T:    enc.bytes[0] = 8'h09;
          CH_U: begin
            enc.n      = 3'd0;
            hex_nxt    = '0;
            digits_nxt = '0;
            mode_nxt   = MODE_HEX_HI;
          end
          default: enc.bytes[0] = in_byte;
        endcase
      end
      MODE_HEX_HI, MODE_HEX_LO: begin
        if (!hd[4]) begin
          status = ST_ERR;
        end else if (digits_r != 3'd3) begin
          hex_nxt    = hv;
          digits_nxt = digits_r + 3'd1;
        end else begin
          hex_nxt    = hv;
          digits_nxt = '0;
          if (mode_r == MODE_HEX_HI) begin
            if (hv >= 16'hD800 && hv <= 16'hDBFF) begin
              high_nxt = hv[9:0];
              mode_nxt = MODE_WAIT_BS;
            end else if (hv >= 16'hDC00 && hv <= 16'hDFFF) begin
              // lone low surrogate
              status = ST_ERR;
            end else begin
              cp       = {5'd0, hv};
              enc      = utf8_enc(cp);
              mode_nxt = MODE_STR;
            end
          end else begin
            if (hv >= 16'hDC00 && hv <= 16'hDFFF) begin
              cp       = 21'h10000 + {1'b0, high_r, hv[9:0]};
              enc      = utf8_enc(cp);
              mode_nxt = MODE_STR;
              high_nxt = '0;
            end else begin
              status = ST_ERR;
            end
          end
        end
      end
      MODE_WAIT_BS: begin
        if (in_byte == CH_BSL) mode_nxt = MODE_WAIT_U;
        else status = ST_ERR;
      end
      MODE_WAIT_U: begin
        if (in_byte == CH_U) begin
          hex_nxt    = '0;
          digits_nxt = '0;
          mode_nxt   = MODE_HEX_LO;
        end else begin
          status = ST_ERR;
        end
      end
      default: status = ST_ERR;
    endcase

    if (status != ST_RUN) begin
      mode_nxt   = MODE_IDLE;
      hex_nxt    = '0;
      digits_nxt = '0;
      high_nxt   = '0;
      enc.n      = 3'd0;
    end

    chars_nxt = chars_mid;
    bytes_nxt = bytes_mid;
    if (enc.n != 3'd0) begin
      // continuation bytes passed raw do not start a character
      if (enc.n > 3'd1 || enc.bytes[0][7:6] != 2'b10)
        chars_nxt = sat_add(chars_mid, 3'd1);
      bytes_nxt = sat_add(bytes_mid, enc.n);
    end
  end

  assign push            = accept && (enc.n != 3'd0 || status != ST_RUN);
  assign push_job.bytes  = enc.bytes;
  assign push_job.n      = enc.n;
  assign push_job.status = status;
  assign push_job.chars  = OUT_CNT_W'(chars_nxt);
  assign push_job.dbytes = OUT_CNT_W'(bytes_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      hex_r    <= '0;
      digits_r <= '0;
      high_r   <= '0;
      chars_r  <= '0;
      bytes_r  <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      hex_r    <= hex_nxt;
      digits_r <= digits_nxt;
      high_r   <= high_nxt;
      chars_r  <= chars_nxt;
      bytes_r  <= bytes_nxt;
    end
  end

endmodule

/* hw/rtl/jsu_queue.sv */
// jsu_queue: short job queue between front decoder and back serialiser
// depends on jsu_pkg
module jsu_queue import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       head_job,
  output q_status_t  q_stat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/jsu_back.sv */
// jsu_back: serialises the head job of the queue into result beats
// depends on jsu_pkg
module jsu_back import jsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  job_t                  head_job,
  input  q_status_t             q_stat,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic                  out_data_valid,
  output logic                  out_run_last,
  output logic [1:0]            out_status,
  output logic [OUT_CNT_W-1:0]  out_char_count,
  output logic [OUT_CNT_W-1:0]  out_decoded_bytes
);

  logic [1:0] k_r;
  logic [2:0] total;
  logic       is_data;
  logic       last;
  logic       take;

  assign total     = head_job.n + {2'b00, head_job.status != ST_RUN};
  assign is_data   = {1'b0, k_r} < head_job.n;
  assign last      = ({1'b0, k_r} + 3'd1) == total;
  assign out_valid = !q_stat.empty;
  assign take      = out_valid && !out_stall;
  assign pop       = take && last;

  assign out_byte          = is_data ? head_job.bytes[k_r] : 8'h00;
  assign out_data_valid    = is_data;
  assign out_run_last      = last;
  assign out_status        = is_data ? ST_RUN : head_job.status;
  assign out_char_count    = head_job.chars;
  assign out_decoded_bytes = head_job.dbytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (take) begin
      k_r <= last ? 2'd0 : k_r + 2'd1;
    end
  end

endmodule

/* hw/rtl/json_string_unescape.sv */
// json_string_unescape: top level, joins front decoder, job queue and back serialiser
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
//
// usage: feed the bytes of a quoted json string on the in_ channel, opening quote
// first, one beat per byte. each byte is accepted when in_valid is high and
// in_stall is low. the out_ channel gives the decoded utf-8 bytes as beats with
// out_data_valid set, then one status beat at the closing quote (done) or on an
// error. out_run_last marks the last beat caused by one input byte; bytes that
// complete nothing (opening quote, backslash, hex digits) give no beat.
// the job of a byte that gives beats is registered in the job queue, read from its head.
// throughput: one input byte per cycle while in_stall is low; a \u escape takes one
// output beat per utf-8 byte, the back serialiser emitting one beat a cycle while
// out_stall is low. a four-entry job queue parts the two sides, so input keeps
// flowing while the receiver stalls, until the queue fills and in_stall rises.
// reset: decoder idle awaiting an opening quote, counters cleared, queue empty.
module json_string_unescape import jsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_data_valid,
  output logic                  out_run_last,
  output logic [1:0]            out_status,
  output logic [OUT_CNT_W-1:0]  out_char_count,
  output logic [OUT_CNT_W-1:0]  out_decoded_bytes
);

  q_status_t q_stat;
  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;

  assign in_stall = q_stat.full;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_data_valid    (out_data_valid),
    .out_run_last      (out_run_last),
    .out_status        (out_status),
    .out_char_count    (out_char_count),
    .out_decoded_bytes (out_decoded_bytes)
  );

endmodule

/* sim/json_string_unescape_tb.sv */
`timescale 1ns / 1ps
// json_string_unescape_tb: self-checking bench for the json string unescaper
// depends on jsu_pkg and the json_string_unescape top level
module json_string_unescape_tb;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = "\"";
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_B      = "b";
  localparam logic [7:0] CH_F      = "f";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_R      = "r";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_U      = "u";
  localparam logic [7:0][7:0] SIMPLE_ESC =
    {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;

  typedef enum logic [2:0] {
    M_IDLE, M_STR, M_ESC, M_HEX_HI, M_WAIT_BS, M_WAIT_U, M_HEX_LO
  } dec_mode_t;

  typedef struct packed {
    logic [7:0]           data;
    logic                 dv;
    logic                 last;
    logic [1:0]           st;
    logic [OUT_CNT_W-1:0] chars;
    logic [OUT_CNT_W-1:0] nbytes;
  } beat_t;

  class unescape_scoreboard;
    dec_mode_t             mode;
    logic [15:0]           hex_acc;
    int                    hex_count;
    logic [9:0]            high_half;
    logic [COUNT_BITS-1:0] char_total;
    logic [COUNT_BITS-1:0] byte_total;
    beat_t                 decoded_beats[$];
    int                    mismatches;

    function new();
      mode       = M_IDLE;
      hex_acc    = '0;
      hex_count  = 0;
      high_half  = '0;
      char_total = '0;
      byte_total = '0;
      mismatches = 0;
    endfunction

    function int to_utf8(input logic [20:0] cp, output logic [3:0][7:0] enc);
      enc = '0;
      if (cp < 21'h80) begin
        enc[0] = cp[7:0];
        return 1;
      end
      if (cp < 21'h800) begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
        return 2;
      end
      if (cp < 21'h10000) begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
        return 3;
      end
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      return 4;
    endfunction

    // works out the beats caused by one accepted input byte
    function void decode_byte(input logic [7:0] b);
      logic [3:0][7:0]     enc;
      logic [1:0]          st;
      logic [COUNT_BITS:0] sum;
      logic [20:0]         cp;
      int                  n;
      int                  nib;
      int                  total;
      beat_t               bt;
      enc = '0;
      n   = 0;
      st  = ST_RUN;
      nib = -1;
      case (mode)
        M_IDLE: begin
          if (b == CH_QUOTE) begin
            char_total = '0;
            byte_total = '0;
            hex_acc    = '0;
            hex_count  = 0;
            high_half  = '0;
            mode       = M_STR;
          end else begin
            st = ST_ERR;
          end
        end
        M_STR: begin
          if (b == CH_QUOTE) begin
            st = ST_DONE;
          end else if (b == CH_BSLASH) begin
            mode = M_ESC;
          end else begin
            enc[0] = b;
            n = 1;
          end
        end
        M_ESC: begin
          mode = M_STR;
          n = 1;
          case (b)
            CH_B: enc[0] = 8'h08;
            CH_F: enc[0] = 8'h0C;
            CH_N: enc[0] = 8'h0A;
            CH_R: enc[0] = 8'h0D;
            CH_T: enc[0] = 8'h09;
            CH_U: begin
              n = 0;
              hex_acc = '0;
              hex_count = 0;
              mode = M_HEX_HI;
            end
            default: enc[0] = b;
          endcase
        end
        M_HEX_HI, M_HEX_LO: begin
          if (b >= "0" && b <= "9") nib = b - "0";
          else if (b >= "a" && b <= "f") nib = b - "a" + 10;
          else if (b >= "A" && b <= "F") nib = b - "A" + 10;
          if (nib < 0) begin
            st = ST_ERR;
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            hex_count++;
            if (hex_count == 4) begin
              hex_count = 0;
              if (mode == M_HEX_HI) begin
                if (hex_acc[15:10] == 6'b110110) begin
                  high_half = hex_acc[9:0];
                  mode = M_WAIT_BS;
                end else if (hex_acc[15:10] == 6'b110111) begin
                  st = ST_ERR;
                end else begin
                  n = to_utf8({5'd0, hex_acc}, enc);
                  mode = M_STR;
                end
              end else if (hex_acc[15:10] == 6'b110111) begin
                cp = 21'h10000 + {high_half, hex_acc[9:0]};
                n = to_utf8(cp, enc);
                mode = M_STR;
                high_half = '0;
              end else begin
                st = ST_ERR;
              end
            end
          end
        end
        M_WAIT_BS: begin
          if (b == CH_BSLASH) mode = M_WAIT_U;
          else st = ST_ERR;
        end
        M_WAIT_U: begin
          if (b == CH_U) begin
            hex_acc = '0;
            hex_count = 0;
            mode = M_HEX_LO;
          end else begin
            st = ST_ERR;
          end
        end
        default: st = ST_ERR;
      endcase

      if (st != ST_RUN) begin
        mode      = M_IDLE;
        hex_acc   = '0;
        hex_count = 0;
        high_half = '0;
        n         = 0;
      end

      if (n > 0) begin
        // continuation bytes on their own do not start a character
        if (n > 1 || enc[0][7:6] != 2'b10)
          char_total = (char_total == '1) ? char_total : char_total + 1'b1;
        sum = {1'b0, byte_total} + (COUNT_BITS + 1)'(n);
        byte_total = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end

      total = n + ((st != ST_RUN) ? 1 : 0);
      for (int k = 0; k < total; k++) begin
        bt.data   = (k < n) ? enc[k] : 8'h00;
        bt.dv     = (k < n);
        bt.last   = (k == total - 1);
        bt.st     = (k < n) ? ST_RUN : st;
        bt.chars  = char_total[OUT_CNT_W-1:0];
        bt.nbytes = byte_total[OUT_CNT_W-1:0];
        decoded_beats.push_back(bt);
      end
    endfunction

    function void check_beat(input beat_t got);
      beat_t want;
      if (decoded_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: byte %02h dv %0b last %0b status %0d chars %0d bytes %0d",
                   got.data, got.dv, got.last, got.st, got.chars, got.nbytes);
        return;
      end
      want = decoded_beats.pop_front();
      if (got.data !== want.data || got.dv !== want.dv || got.last !== want.last ||
          got.st !== want.st || got.chars !== want.chars || got.nbytes !== want.nbytes) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat mismatch: expected byte %02h dv %0b last %0b status %0d chars %0d bytes %0d",
                   want.data, want.dv, want.last, want.st, want.chars, want.nbytes);
          $display("               actual   byte %02h dv %0b last %0b status %0d chars %0d bytes %0d",
                   got.data, got.dv, got.last, got.st, got.chars, got.nbytes);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_byte;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_data_valid;
  logic                 out_run_last;
  logic [1:0]           out_status;
  logic [OUT_CNT_W-1:0] out_char_count;
  logic [OUT_CNT_W-1:0] out_decoded_bytes;

  unescape_scoreboard sb;
  beat_t              seen;
  int                 tx_idle_pct = 7;
  int                 rx_idle_pct = 79;
  bit                 hold_request = 1'b0;
  int                 hold_left = 0;
  int                 quiet_cycles = 0;
  int                 sent = 0;
  logic [2:0]         esc_turn = '0;

  json_string_unescape DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_data_valid    (out_data_valid),
    .out_run_last      (out_run_last),
    .out_status        (out_status),
    .out_char_count    (out_char_count),
    .out_decoded_bytes (out_decoded_bytes)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // receiver side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.decode_byte(in_byte);
      if (out_valid && !out_stall) begin
        seen = {out_byte, out_data_valid, out_run_last, out_status,
                out_char_count, out_decoded_bytes};
        sb.check_beat(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // backslash, u and four hex digits in mixed case
  task automatic send_uesc(input logic [15:0] v);
    logic [3:0] nib;
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 10) send_byte("0" + nib);
      else if ($urandom_range(1)) send_byte("A" + nib - 8'd10);
      else send_byte("a" + nib - 8'd10);
    end
  endtask

  task automatic send_random_string();
    int          parts;
    int          kind;
    bit          broken;
    logic [7:0]  b;
    logic [15:0] v;
    broken = 1'b0;
    send_byte(CH_QUOTE);
    parts = $urandom_range(10, 1);
    for (int p = 0; p < parts; p++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
        send_byte(b);
      end else if (kind < 62) begin
        send_byte(CH_BSLASH);
        // walk the simple escapes in turn, sometimes an arbitrary byte
        if ($urandom_range(3) != 0) begin
          b = SIMPLE_ESC[esc_turn];
          esc_turn++;
        end else begin
          do b = 8'($urandom_range(255)); while (b == CH_U);
        end
        send_byte(b);
      end else if (kind < 78) begin
        case ($urandom_range(2))
          0: v = 16'($urandom_range(16'h7F));
          1: v = 16'($urandom_range(16'h7FF, 16'h80));
          default: do v = 16'($urandom_range(16'hFFFF, 16'h800)); while (v[15:11] == 5'b11011);
        endcase
        send_uesc(v);
      end else if (kind < 92) begin
        send_uesc(16'($urandom_range(16'hDBFF, 16'hD800)));
        send_uesc(16'($urandom_range(16'hDFFF, 16'hDC00)));
      end else begin
        broken = 1'b1;
        case ($urandom_range(4))
          0: begin
            // bad hex digit, in the high or the low half
            if ($urandom_range(1)) send_uesc(16'($urandom_range(16'hDBFF, 16'hD800)));
            send_byte(CH_BSLASH);
            send_byte(CH_U);
            repeat ($urandom_range(3)) send_byte(8'("0" + $urandom_range(9)));
            do b = 8'($urandom_range(255));
            while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
            send_byte(b);
          end
          1: send_uesc(16'($urandom_range(16'hDFFF, 16'hDC00)));
          2: begin
            send_uesc(16'($urandom_range(16'hDBFF, 16'hD800)));
            do b = 8'($urandom_range(255)); while (b == CH_BSLASH);
            send_byte(b);
          end
          3: begin
            send_uesc(16'($urandom_range(16'hDBFF, 16'hD800)));
            send_byte(CH_BSLASH);
            do b = 8'($urandom_range(255)); while (b == CH_U);
            send_byte(b);
          end
          default: begin
            send_uesc(16'($urandom_range(16'hDBFF, 16'hD800)));
            do v = 16'($urandom_range(16'hFFFF)); while (v[15:10] == 6'b110111);
            send_uesc(v);
          end
        endcase
        break;
      end
    end
    if (!broken) send_byte(CH_QUOTE);
    // stray byte while idle
    if ($urandom_range(7) == 0) begin
      do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
      send_byte(b);
    end
  endtask

  initial begin
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);           // no opening quote
    send_byte(CH_QUOTE);
    send_byte(8'hFF);
    send_byte(8'h80);           // lone continuation byte, not a character
    send_uesc(16'hFFFF);
    send_uesc(16'hDBFF);        // largest code point
    send_uesc(16'hDFFF);
    send_byte(CH_QUOTE);

    while (sent < 95) send_random_string();
    tx_idle_pct = 79;
    rx_idle_pct = 7;
    while (sent < 170) send_random_string();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    while (sent < 240) send_random_string();
    in_valid <= 1'b0;

    while (sb.decoded_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.decoded_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape.sv
sim/json_string_unescape_tb.sv
